/* rtl/frame_receiver_with_sum_macros.svh */
// Assertion macros shared by the checker of the frame receiver.
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
`ifndef FRAME_RECEIVER_WITH_SUM_MACROS_SVH
`define FRAME_RECEIVER_WITH_SUM_MACROS_SVH

// same-cycle implication
`define FRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/frs_pkg.sv */
// Package of the frame receiver: widths, register indexes, status codes
// and the receiver phase type. No dependencies.
package frs_pkg;

  localparam int BufDepth = 64;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int LenW     = 7;
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_HDR_FIRST   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HDR_SECOND  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [ByteW-1:0] HdrFirstRst   = 8'h7e;
  localparam logic [ByteW-1:0] HdrSecondRst  = 8'h81;
  localparam logic [LenW-1:0]  MaxPayloadRst = 7'd50;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_GOOD    = 2'd1;
  localparam logic [1:0] ST_SUM_ERR = 2'd2;
  localparam logic [1:0] ST_LEN_ERR = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

endpackage

/* rtl/frs_ifs.sv */
// Request and response channel interfaces of the frame receiver.
// Valid/ready handshake; uses frs_pkg for field widths.
interface frs_req_if import frs_pkg::*;;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [ByteW-1:0] rx_byte;
  logic [AddrW-1:0] read_index;

  modport source (output valid, req_type, rx_byte, read_index, input ready);
  modport sink   (input valid, req_type, rx_byte, read_index, output ready);
endinterface

interface frs_rsp_if import frs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ByteW-1:0] read_data;
  logic [LenW-1:0]  frame_length;

  modport source (output valid, status, read_data, frame_length, input ready);
  modport sink   (input valid, status, read_data, frame_length, output ready);
endinterface

/* rtl/frs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module frs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/frame_receiver_with_sum.sv */
// Frame receiver: header hunt, length check, payload buffer, additive checksum.
// Uses frs_pkg, frs_req_if / frs_rsp_if and frs_ram.
//
//   channel  dir  fields                              transaction
//   req_i    in   req_type, rx_byte, read_index       valid & ready
//   rsp_o    out  status, read_data, frame_length     valid & ready
//   cfg      in   cfg_idx_i, cfg_wdata_i              cfg_we_i
//
// One transaction per cycle in while req_i.ready is high, one result per transaction out;
// results pass the RAM stage (registered RAM read port), then the output register.
// Two result slots (RAM stage and output register); req_i.ready drops only
// when both are full and rsp_o is stalled.
// Reset clears phase, counters, sum and good length; the payload RAM is not cleared.
module frame_receiver_with_sum import frs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  frs_req_if.sink             req_i,
  frs_rsp_if.source           rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [LenW-1:0] BufDepthLen = LenW'(BufDepth);

  logic [ByteW-1:0] hdr_first_q, hdr_second_q;
  logic [LenW-1:0]  max_payload_q;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] prev_q, prev_d;
  logic [ByteW-1:0] len_lo_q, len_lo_d;
  logic [LenW-1:0]  exp_len_q, exp_len_d;
  logic [LenW-1:0]  byte_idx_q, byte_idx_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [LenW-1:0]  good_len_q, good_len_d;

  logic             accept, rx_fire, hdr_hit, len_ok, pay_end, wr_en;
  logic [LenW-1:0]  limit, idx_inc;
  logic [15:0]      full_len;
  logic [1:0]       st;
  logic [ByteW-1:0] ram_rdata;

  logic             s1_v_q, s1_rd_q, s2_v_q, s2_load;
  logic [1:0]       s1_st_q, s2_st_q;
  logic [LenW-1:0]  s1_len_q, s2_len_q;
  logic [ByteW-1:0] s2_data_q;

  assign s2_load     = s1_v_q && (!s2_v_q || rsp_o.ready);
  assign req_i.ready = !s1_v_q || s2_load;
  assign accept      = req_i.valid && req_i.ready;
  assign rx_fire     = accept && !req_i.req_type;

  assign hdr_hit   = (prev_q == hdr_first_q) && (req_i.rx_byte == hdr_second_q);
  assign limit     = (max_payload_q > BufDepthLen) ? BufDepthLen : max_payload_q;
  assign full_len  = {req_i.rx_byte, len_lo_q};
  assign len_ok    = full_len <= 16'(limit);
  assign idx_inc   = byte_idx_q + 1'b1;
  assign pay_end   = idx_inc >= exp_len_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q   <= HdrFirstRst;
      hdr_second_q  <= HdrSecondRst;
      max_payload_q <= MaxPayloadRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HDR_FIRST:   hdr_first_q   <= cfg_wdata_i;
        CFG_HDR_SECOND:  hdr_second_q  <= cfg_wdata_i;
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (rx_fire) begin
      unique case (phase_q)
        PH_IDLE:    if (hdr_hit) phase_d = PH_LEN_LO;
        PH_LEN_LO:  phase_d = PH_LEN_HI;
        PH_LEN_HI: begin
          if (!len_ok) begin
            phase_d = PH_IDLE;
          end else if (full_len == '0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: if (pay_end) phase_d = PH_CHECK;
        PH_CHECK:   phase_d = PH_IDLE;
        default:    phase_d = PH_IDLE;
      endcase
    end
  end

  // datapath and status
  always_comb begin
    prev_d     = prev_q;
    len_lo_d   = len_lo_q;
    exp_len_d  = exp_len_q;
    byte_idx_d = byte_idx_q;
    sum_d      = sum_q;
    good_len_d = good_len_q;
    st         = ST_NONE;
    wr_en      = 1'b0;
    if (rx_fire) begin
      prev_d = req_i.rx_byte;
      unique case (phase_q)
        PH_LEN_LO: len_lo_d = req_i.rx_byte;
        PH_LEN_HI: begin
          if (!len_ok) begin
            st = ST_LEN_ERR;
          end else begin
            exp_len_d  = full_len[LenW-1:0];
            byte_idx_d = '0;
            sum_d      = '0;
          end
        end
        PH_PAYLOAD: begin
          wr_en      = 1'b1;
          sum_d      = sum_q + req_i.rx_byte;
          byte_idx_d = pay_end ? '0 : idx_inc;
        end
        PH_CHECK: begin
          if (sum_q == req_i.rx_byte) begin
            good_len_d = exp_len_q;
            st         = ST_GOOD;
          end else begin
            st = ST_SUM_ERR;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      prev_q     <= '0;
      len_lo_q   <= '0;
      exp_len_q  <= '0;
      byte_idx_q <= '0;
      sum_q      <= '0;
      good_len_q <= '0;
    end else begin
      phase_q    <= phase_d;
      prev_q     <= prev_d;
      len_lo_q   <= len_lo_d;
      exp_len_q  <= exp_len_d;
      byte_idx_q <= byte_idx_d;
      sum_q      <= sum_d;
      good_len_q <= good_len_d;
    end
  end

  frs_ram #(
    .Width (ByteW),
    .Depth (BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (byte_idx_q[AddrW-1:0]),
    .wdata_i (req_i.rx_byte),
    .re_i    (accept),
    .raddr_i (req_i.read_index),
    .rdata_o (ram_rdata)
  );

  // stage 1: waits on RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s2_load) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q  <= req_i.req_type;
      s1_st_q  <= st;
      s1_len_q <= good_len_d;
    end
  end

  // stage 2: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_load) begin
      s2_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_st_q   <= s1_st_q;
      s2_len_q  <= s1_len_q;
      s2_data_q <= s1_rd_q ? ram_rdata : '0;
    end
  end

  assign rsp_o.valid        = s2_v_q;
  assign rsp_o.status       = s2_st_q;
  assign rsp_o.read_data    = s2_data_q;
  assign rsp_o.frame_length = s2_len_q;

endmodule

/* rtl/frs_checker.sv */
// Port-level checker for the frame receiver, bound to the top level.
// Uses frs_pkg and frame_receiver_with_sum_macros.svh.
`include "frame_receiver_with_sum_macros.svh"

module frs_checker import frs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [1:0]       status_i,
  input logic [ByteW-1:0] read_data_i,
  input logic [LenW-1:0]  frame_length_i
);

  localparam logic [LenW-1:0] MaxLen = LenW'(BufDepth);

  `FRS_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(status_i) && $stable(read_data_i) && $stable(frame_length_i), "stalled response changed")
  `FRS_ASSERT_NOW(a_rsp_drop, $fell(rsp_valid_i), $past(rsp_ready_i), "response dropped without transaction")
  `FRS_ASSERT_NOW(a_data_zero, rsp_valid_i && (status_i != ST_NONE), read_data_i == '0, "nonzero read data on frame status")
  `FRS_ASSERT_NOW(a_len_max, rsp_valid_i, frame_length_i <= MaxLen, "frame length above buffer depth")

endmodule

bind frame_receiver_with_sum frs_checker u_frs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .read_data_i    (rsp_o.read_data),
  .frame_length_i (rsp_o.frame_length)
);

/* tb/frame_receiver_with_sum_tb.sv */
// Self-checking bench for frame_receiver_with_sum: a stimulus script, then random frames.
// Holds its own deframer predictor and compares every response in order.
// Depends on frs_pkg, frs_req_if / frs_rsp_if and the frame_receiver_with_sum RTL.
module frame_receiver_with_sum_tb;
  import frs_pkg::*;

  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_READ = 1'b1;
  localparam bit   PRED     = 1'b0;
  localparam bit   CHK      = 1'b1;
  localparam int   ITEMS_PER_PHASE = 335;
  localparam int   LIMIT_CYCLES    = 400000;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] rx_byte;
    logic [AddrW-1:0] read_index;
  } line_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ByteW-1:0] read_data;
    logic [LenW-1:0]  frame_length;
  } frame_rsp_t;

  typedef struct packed {
    logic             typed;
    logic             req_type;
    logic [ByteW-1:0] rx_byte;
    logic [AddrW-1:0] read_index;
    logic [1:0]       status;
    logic [ByteW-1:0] read_data;
    logic [LenW-1:0]  frame_length;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{PRED, REQ_RX,   8'h7e, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h81, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h03, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h00, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'hff, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h01, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h80, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{CHK,  REQ_RX,   8'h80, 6'd0, ST_GOOD,    8'h00, 7'd3},
    '{CHK,  REQ_READ, 8'h00, 6'd0, ST_NONE,    8'hff, 7'd3},
    '{PRED, REQ_READ, 8'hff, 6'd2, ST_NONE,    8'h00, 7'd0},
    // zero length: checksum follows the length directly
    '{PRED, REQ_RX,   8'h7e, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h81, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h00, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h00, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{CHK,  REQ_RX,   8'h00, 6'd0, ST_GOOD,    8'h00, 7'd0},
    // one past the limit
    '{PRED, REQ_RX,   8'h7e, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h81, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h33, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{CHK,  REQ_RX,   8'h00, 6'd0, ST_LEN_ERR, 8'h00, 7'd0},
    // high length byte equals the first sync byte, next byte re-syncs
    '{PRED, REQ_RX,   8'h7e, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h81, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h01, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{CHK,  REQ_RX,   8'h7e, 6'd0, ST_LEN_ERR, 8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h81, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h01, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h00, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{PRED, REQ_RX,   8'h55, 6'd0, ST_NONE,    8'h00, 7'd0},
    '{CHK,  REQ_RX,   8'h54, 6'd0, ST_SUM_ERR, 8'h00, 7'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  frs_req_if req_if ();
  frs_rsp_if rsp_if ();

  frame_receiver_with_sum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // deframer state and settings
  logic [ByteW-1:0] hdr_a    = HdrFirstRst;
  logic [ByteW-1:0] hdr_b    = HdrSecondRst;
  logic [LenW-1:0]  len_cap  = MaxPayloadRst;
  phase_e           rx_phase = PH_IDLE;
  logic [ByteW-1:0] prev_rx  = '0;
  logic [15:0]      want_len = '0;
  logic [LenW-1:0]  got_cnt  = '0;
  logic [ByteW-1:0] sum_acc  = '0;
  logic [LenW-1:0]  good_len = '0;
  logic [ByteW-1:0] rx_store [BufDepth];
  logic [BufDepth-1:0] filled = '0;

  frame_rsp_t predicted_rsp [$];
  bit calm = 1'b0;
  int stall_left = 0;
  int n_in = 0, n_good = 0, n_bad_sum = 0, n_bad_len = 0, n_reads = 0, n_err = 0;

  function automatic frame_rsp_t deframe_step(line_req_t it);
    frame_rsp_t r;
    int cap;
    r = '0;
    if (it.req_type == REQ_READ) begin
      r.read_data = rx_store[it.read_index];
    end else begin
      case (rx_phase)
        PH_IDLE: begin
          if (prev_rx == hdr_a && it.rx_byte == hdr_b) begin
            rx_phase = PH_LEN_LO;
            want_len = '0;
          end
        end
        PH_LEN_LO: begin
          want_len = {8'h00, it.rx_byte};
          rx_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          want_len[15:8] = it.rx_byte;
          cap = (int'(len_cap) > BufDepth) ? BufDepth : int'(len_cap);
          if (int'(want_len) > cap) begin
            rx_phase = PH_IDLE;
            r.status = ST_LEN_ERR;
          end else begin
            got_cnt = '0;
            sum_acc = '0;
            rx_phase = (want_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (int'(got_cnt) < BufDepth) begin
            rx_store[got_cnt[AddrW-1:0]] = it.rx_byte;
            filled[got_cnt[AddrW-1:0]] = 1'b1;
          end
          sum_acc = sum_acc + it.rx_byte;
          got_cnt = got_cnt + 1'b1;
          if (16'(got_cnt) >= want_len) begin
            got_cnt = '0;
            rx_phase = PH_CHECK;
          end
        end
        PH_CHECK: begin
          rx_phase = PH_IDLE;
          if (sum_acc == it.rx_byte) begin
            good_len = want_len[LenW-1:0];
            r.status = ST_GOOD;
          end else begin
            r.status = ST_SUM_ERR;
          end
        end
        default: rx_phase = PH_IDLE;
      endcase
      prev_rx = it.rx_byte;
    end
    r.frame_length = good_len;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_req(input line_req_t it, input bit typed, input frame_rsp_t typed_rsp);
    frame_rsp_t p;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid      <= 1'b1;
    req_if.req_type   <= it.req_type;
    req_if.rx_byte    <= it.rx_byte;
    req_if.read_index <= it.read_index;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    p = deframe_step(it);
    predicted_rsp.push_back(typed ? typed_rsp : p);
    n_in++;
    if (it.req_type == REQ_READ) n_reads++;
    if (p.status == ST_GOOD) n_good++;
    if (p.status == ST_SUM_ERR) n_bad_sum++;
    if (p.status == ST_LEN_ERR) n_bad_len++;
  endtask

  task automatic send_rx(input logic [ByteW-1:0] b);
    line_req_t it;
    it.req_type   = REQ_RX;
    it.rx_byte    = b;
    it.read_index = AddrW'($urandom);
    send_req(it, 1'b0, '0);
  endtask

  // only entries already written by a payload are read
  task automatic send_read();
    line_req_t it;
    if (filled == '0) begin
      send_rx(ByteW'($urandom));
    end else begin
      it.req_type = REQ_READ;
      it.rx_byte  = ByteW'($urandom);
      do it.read_index = AddrW'($urandom); while (!filled[it.read_index]);
      send_req(it, 1'b0, '0);
    end
  endtask

  task automatic send_frame(input bit full);
    int cap, cut_at;
    logic [15:0] len;
    logic [ByteW-1:0] sum, b;
    logic [ByteW-1:0] seq [$];
    cap = (int'(len_cap) > BufDepth) ? BufDepth : int'(len_cap);
    case ($urandom_range(0, 19)) inside
      [0:13]:  len = 16'($urandom_range(0, (cap < 12) ? cap : 12));
      [14:16]: len = 16'($urandom_range(0, cap));
      [17:18]: len = 16'(cap + $urandom_range(1, 4));
      default: len = 16'($urandom);
    endcase
    if (full) len = 16'(cap);
    seq.push_back(hdr_a);
    seq.push_back(hdr_b);
    seq.push_back(len[7:0]);
    seq.push_back(len[15:8]);
    if (int'(len) <= cap) begin
      sum = '0;
      for (int i = 0; i < int'(len); i++) begin
        b = ByteW'($urandom);
        seq.push_back(b);
        sum = sum + b;
      end
      if ($urandom_range(0, 9) == 0) sum = sum ^ ByteW'($urandom_range(1, 255));
      seq.push_back(sum);
    end
    cut_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int i = 0; i < cut_at; i++) begin
      if ($urandom_range(0, 9) == 0) send_read();
      send_rx(seq[i]);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (predicted_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HDR_FIRST:   hdr_a = val;
      CFG_HDR_SECOND:  hdr_b = val;
      CFG_MAX_PAYLOAD: len_cap = val[LenW-1:0];
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    frame_rsp_t e;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (predicted_rsp.size() == 0) begin
        $error("response transaction with nothing pending");
        n_err++;
      end else begin
        e = predicted_rsp.pop_front();
        if (rsp_if.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_if.status);
          n_err++;
        end
        if (rsp_if.read_data !== e.read_data) begin
          $error("read_data: expected %0h, got %0h", e.read_data, rsp_if.read_data);
          n_err++;
        end
        if (rsp_if.frame_length !== e.frame_length) begin
          $error("frame_length: expected %0d, got %0d", e.frame_length, rsp_if.frame_length);
          n_err++;
        end
      end
    end
  end

  initial begin
    int goal;
    logic [ByteW-1:0] a, b;
    logic [LenW-1:0] m;
    bit first;
    line_req_t it;
    frame_rsp_t rsp;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_RX;
    req_if.rx_byte    = '0;
    req_if.read_index = '0;
    rsp_if.ready      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      it  = '{SCRIPT[i].req_type, SCRIPT[i].rx_byte, SCRIPT[i].read_index};
      rsp = '{SCRIPT[i].status, SCRIPT[i].read_data, SCRIPT[i].frame_length};
      send_req(it, SCRIPT[i].typed, rsp);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin a = 8'h00; b = 8'hff; m = 7'd64; end
        1: begin a = 8'hff; b = 8'h00; m = 7'd0; end
        2: begin a = ByteW'($urandom); b = ByteW'($urandom); m = LenW'($urandom_range(1, 63)); end
        default: begin a = 8'h5a; b = 8'h5a; m = 7'd20; end
      endcase
      write_reg(CFG_HDR_FIRST, a);
      write_reg(CFG_HDR_SECOND, b);
      write_reg(CFG_MAX_PAYLOAD, {1'b0, m});
      goal  = n_in + ITEMS_PER_PHASE;
      first = 1'b1;
      while (n_in < goal) begin
        calm = ($urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) == 0) send_read();
          else send_rx(ByteW'($urandom));
        end
        // in phase 0 the first frame is at the full buffer size and, unless cut short, fills every entry
        send_frame(first && ph == 0);
        first = 1'b0;
      end
    end

    drain();
    $display("summary: %0d transactions in, %0d good frames, %0d bad sums, %0d length faults",
             n_in, n_good, n_bad_sum, n_bad_len);
    $display("summary: %0d buffer reads over reset plus four header/limit settings", n_reads);
    if (n_err == 0) begin
      $display("frame_receiver_with_sum_tb: clean");
    end else begin
      $display("frame_receiver_with_sum_tb: errors");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("frame_receiver_with_sum_tb: errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/frs_pkg.sv
rtl/frs_ifs.sv
rtl/frs_ram.sv
rtl/frame_receiver_with_sum.sv
rtl/frs_checker.sv
tb/frame_receiver_with_sum_tb.sv
